@@ design/mst_pkg.sv @@
// Shared types and constants for the Prim spanning tree block.
`default_nettype none

package mst_pkg;

    localparam int MAX_VERTICES_DEF  = 32;
    localparam int WEIGHT_BITS_DEF   = 16;
    localparam int TOTAL_BITS        = 21;
    localparam int VERTEX_FIELD_BITS = 5;
    localparam int OPCODE_BITS       = 2;
    localparam int VCOUNT_BITS       = 6;

    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 6'd32;

    localparam logic [OPCODE_BITS-1:0] OP_ADD   = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_RUN   = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR = 2'd2;
    localparam logic [OPCODE_BITS-1:0] OP_NOP   = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_ADD_WR2,
        ST_RUN_INIT,
        ST_SEARCH,
        ST_PICK,
        ST_RELAX,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic init;
        logic seed;
        logic pick;
        logic relax;
    } mst_ctl_t;

endpackage

`default_nettype wire

@@ design/mst_ram.sv @@
// Single write port, single registered read port memory for edge weights.
`default_nettype none

module mst_ram #(
    parameter int AW = 10,
    parameter int DW = 17
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [1<<AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/mst_cell.sv @@
// One vertex cell: key, parent and flags, plus one stage of the minimum search chain.
`default_nettype none

module mst_cell #(
    parameter int IDX = 0,
    parameter int VB  = 5,
    parameter int WB  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mst_pkg::mst_ctl_t    ctl,
    input  wire logic [VB-1:0]        sel_idx,
    input  wire logic [VB-1:0]        relax_v,
    input  wire logic                 relax_present,
    input  wire logic signed [WB-1:0] relax_w,
    input  wire logic                 cand_in_found,
    input  wire logic signed [WB-1:0] cand_in_key,
    input  wire logic [VB-1:0]        cand_in_idx,
    output logic                      cand_found,
    output logic signed [WB-1:0]      cand_key,
    output logic [VB-1:0]             cand_idx,
    output logic                      in_tree,
    output logic signed [WB-1:0]      key,
    output logic [VB-1:0]             parent
);

    localparam logic [VB-1:0] ME = VB'(IDX);

    logic                 known_reg, known_next;
    logic                 in_tree_reg, in_tree_next;
    logic signed [WB-1:0] key_reg, key_next;
    logic [VB-1:0]        parent_reg, parent_next;
    logic                 cf_reg, cf_next;
    logic signed [WB-1:0] ck_reg, ck_next;
    logic [VB-1:0]        ci_reg, ci_next;
    logic                 own_ok;

    always_comb
    begin
        known_next   = known_reg;
        in_tree_next = in_tree_reg;
        key_next     = key_reg;
        parent_next  = parent_reg;
        if (ctl.init)
        begin
            known_next   = 1'b0;
            in_tree_next = 1'b0;
            if (ctl.seed && sel_idx == ME)
            begin
                known_next  = 1'b1;
                key_next    = '0;
                parent_next = ME;
            end
        end
        else if (ctl.pick)
        begin
            if (sel_idx == ME)
            begin
                in_tree_next = 1'b1;
            end
        end
        else if (ctl.relax)
        begin
            if (relax_v == ME && !in_tree_reg && relax_present
                && (!known_reg || relax_w < key_reg))
            begin
                known_next  = 1'b1;
                key_next    = relax_w;
                parent_next = sel_idx;
            end
        end
    end

    assign own_ok = known_reg && !in_tree_reg;

    always_comb
    begin
        if (own_ok && (!cand_in_found || key_reg < cand_in_key))
        begin
            cf_next = 1'b1;
            ck_next = key_reg;
            ci_next = ME;
        end
        else
        begin
            cf_next = cand_in_found;
            ck_next = cand_in_key;
            ci_next = cand_in_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg   <= 1'b0;
            in_tree_reg <= 1'b0;
            cf_reg      <= 1'b0;
        end
        else
        begin
            known_reg   <= known_next;
            in_tree_reg <= in_tree_next;
            cf_reg      <= cf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        parent_reg <= parent_next;
        ck_reg     <= ck_next;
        ci_reg     <= ci_next;
    end

    assign cand_found = cf_reg;
    assign cand_key   = ck_reg;
    assign cand_idx   = ci_reg;
    assign in_tree    = in_tree_reg;
    assign key        = key_reg;
    assign parent     = parent_reg;

endmodule

`default_nettype wire

@@ design/minimum_spanning_tree_prim.sv @@
// Top level of the Prim minimum spanning tree block over a dense weight store.
//
// Requests enter on item_valid/item_stall; results leave on res_valid/res_stall.
// vertex_count is written through cfg_valid/cfg_ready while the block is idle;
// the user is bound to this, as the block itself does not enforce it. An add
// request reads, compares and, when the entry is empty or the weight lower,
// writes both directions. A clear request sweeps the weight memory, one entry a
// cycle, over 1024 entries at the default size (MAX_VERTICES rounded up to a
// power of two, squared). A run request, for each vertex joined out of n in use,
// waits for the search chain to settle through all cells, picks, then streams
// its n-entry adjacency row out of the memory one entry a cycle. Reporting then
// scans the cells one vertex a cycle, pausing while a stalled result holds.
// One request is in work at a time; item_stall is high until it completes.
// After reset the memory is cleared by the same sweep before the first request
// is taken. A stalled result holds in the output register and reporting pauses
// until the register is free.
`default_nettype none

module minimum_spanning_tree_prim #(
    parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = mst_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [1:0]                    opcode,
    input  wire logic [4:0]                    vertex_a,
    input  wire logic [4:0]                    vertex_b,
    input  wire logic signed [WEIGHT_BITS-1:0] edge_weight,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic                               valid_res,
    output logic [4:0]                         parent_vertex,
    output logic [4:0]                         child_vertex,
    output logic signed [WEIGHT_BITS-1:0]      tree_edge_weight,
    output logic signed [20:0]                 total_weight,
    output logic                               last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [5:0]                    vertex_count
);

    localparam int VB = $clog2(MAX_VERTICES);
    localparam int AW = 2 * VB;
    localparam int CW = AW;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int XW = (NW > mst_pkg::VCOUNT_BITS) ? NW : mst_pkg::VCOUNT_BITS;
    localparam int WB = WEIGHT_BITS;
    localparam int MW = WB + 1;
    localparam int TB = mst_pkg::TOTAL_BITS;
    localparam int FB = mst_pkg::VERTEX_FIELD_BITS;

    mst_pkg::state_t state_reg, state_next;

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [VB-1:0]        a_reg, a_next;
    logic [VB-1:0]        b_reg, b_next;
    logic signed [WB-1:0] w_reg, w_next;
    logic [VB-1:0]        pick_reg, pick_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [VB-1:0]        rv_reg, rv_next;
    logic signed [TB-1:0] total_reg, total_next;
    logic [5:0]           vcount_reg;

    logic                 pend_valid_reg, pend_valid_next;
    logic [VB-1:0]        pend_parent_reg, pend_parent_next;
    logic [VB-1:0]        pend_child_reg, pend_child_next;
    logic signed [WB-1:0] pend_w_reg, pend_w_next;

    logic                 res_valid_reg, res_valid_next;
    logic                 valid_res_reg, valid_res_next;
    logic [FB-1:0]        parent_reg, parent_next;
    logic [FB-1:0]        child_reg, child_next;
    logic signed [WB-1:0] tw_reg, tw_next;
    logic signed [TB-1:0] tot_reg, tot_next;
    logic                 last_reg, last_next;

    logic [VB-1:0] vmod_tbl [32];
    logic [XW-1:0] vc_ext;
    logic [NW-1:0] n_eff;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [MW-1:0] mem_q;

    mst_pkg::mst_ctl_t ctl;
    logic [VB-1:0]     sel_idx;

    logic                 cf   [MAX_VERTICES];
    logic signed [WB-1:0] ck   [MAX_VERTICES];
    logic [VB-1:0]        ci   [MAX_VERTICES];
    logic                 c_in_tree [MAX_VERTICES];
    logic signed [WB-1:0] c_key     [MAX_VERTICES];
    logic [VB-1:0]        c_parent  [MAX_VERTICES];

    logic          accept;
    logic          add_upd;
    logic          slot_free;
    logic [VB-1:0] j;
    logic          at_end;
    logic          qual;
    logic          emit_hold;
    logic          seed_ok;

    genvar k;
    generate
        for (k = 0; k < 32; k++)
        begin : g_vmod
            assign vmod_tbl[k] = VB'(k % MAX_VERTICES);
        end
    endgenerate

    assign vc_ext = XW'(vcount_reg);
    assign n_eff  = (vc_ext == '0) ? NW'(1)
                  : (vc_ext > XW'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                  : NW'(vc_ext);

    mst_ram #(
        .AW (AW),
        .DW (MW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    generate
        for (k = 0; k < MAX_VERTICES; k++)
        begin : g_cell
            logic                 in_f;
            logic signed [WB-1:0] in_k;
            logic [VB-1:0]        in_i;
            if (k == 0)
            begin : g_head
                assign in_f = 1'b0;
                assign in_k = '0;
                assign in_i = '0;
            end
            else
            begin : g_link
                assign in_f = cf[k-1];
                assign in_k = ck[k-1];
                assign in_i = ci[k-1];
            end
            mst_cell #(
                .IDX (k),
                .VB  (VB),
                .WB  (WB)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctl           (ctl),
                .sel_idx       (sel_idx),
                .relax_v       (rv_reg),
                .relax_present (mem_q[WB]),
                .relax_w       (mem_q[WB-1:0]),
                .cand_in_found (in_f),
                .cand_in_key   (in_k),
                .cand_in_idx   (in_i),
                .cand_found    (cf[k]),
                .cand_key      (ck[k]),
                .cand_idx      (ci[k]),
                .in_tree       (c_in_tree[k]),
                .key           (c_key[k]),
                .parent        (c_parent[k])
            );
        end
    endgenerate

    assign accept    = item_valid && !item_stall;
    assign add_upd   = !mem_q[WB] || (w_reg < $signed(mem_q[WB-1:0]));
    assign slot_free = !res_valid_reg || !res_stall;
    assign j         = cnt_reg[VB-1:0];
    assign at_end    = (cnt_reg == CW'(n_eff));
    assign qual      = !at_end && c_in_tree[j] && (j != a_reg);
    assign emit_hold = at_end ? !slot_free : (qual && pend_valid_reg && !slot_free);
    assign seed_ok   = (NW'(a_reg) < n_eff);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mst_pkg::ST_CLEAR:
            begin
                if (&cnt_reg)
                begin
                    state_next = mst_pkg::ST_IDLE;
                end
            end
            mst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        mst_pkg::OP_ADD:   state_next = mst_pkg::ST_ADD_RD;
                        mst_pkg::OP_RUN:   state_next = mst_pkg::ST_RUN_INIT;
                        mst_pkg::OP_CLEAR: state_next = mst_pkg::ST_CLEAR;
                        default:           state_next = mst_pkg::ST_IDLE;
                    endcase
                end
            end
            mst_pkg::ST_ADD_RD:  state_next = mst_pkg::ST_ADD_CMP;
            mst_pkg::ST_ADD_CMP: state_next = add_upd ? mst_pkg::ST_ADD_WR2 : mst_pkg::ST_IDLE;
            mst_pkg::ST_ADD_WR2: state_next = mst_pkg::ST_IDLE;
            mst_pkg::ST_RUN_INIT:
            begin
                state_next = seed_ok ? mst_pkg::ST_SEARCH : mst_pkg::ST_EMIT;
            end
            mst_pkg::ST_SEARCH:
            begin
                if (cnt_reg == CW'(MAX_VERTICES - 1))
                begin
                    state_next = mst_pkg::ST_PICK;
                end
            end
            mst_pkg::ST_PICK:
            begin
                state_next = cf[MAX_VERTICES-1] ? mst_pkg::ST_RELAX : mst_pkg::ST_EMIT;
            end
            mst_pkg::ST_RELAX:
            begin
                if (cnt_reg == CW'(n_eff) - CW'(1))
                begin
                    state_next = mst_pkg::ST_DRAIN;
                end
            end
            mst_pkg::ST_DRAIN: state_next = mst_pkg::ST_SEARCH;
            mst_pkg::ST_EMIT:
            begin
                if (at_end && slot_free)
                begin
                    state_next = mst_pkg::ST_IDLE;
                end
            end
            default: state_next = mst_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall       = (state_reg != mst_pkg::ST_IDLE);
        mem_we           = 1'b0;
        mem_waddr        = {a_reg, b_reg};
        mem_wdata        = {1'b1, w_reg};
        mem_raddr        = {a_reg, b_reg};
        ctl              = '0;
        sel_idx          = pick_reg;
        cnt_next         = cnt_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        w_next           = w_reg;
        pick_next        = pick_reg;
        rd_pend_next     = 1'b0;
        rv_next          = rv_reg;
        total_next       = total_reg;
        pend_valid_next  = pend_valid_reg;
        pend_parent_next = pend_parent_reg;
        pend_child_next  = pend_child_reg;
        pend_w_next      = pend_w_reg;
        res_valid_next   = res_stall ? res_valid_reg : 1'b0;
        valid_res_next   = valid_res_reg;
        parent_next      = parent_reg;
        child_next       = child_reg;
        tw_next          = tw_reg;
        tot_next         = tot_reg;
        last_next        = last_reg;

        if (rd_pend_reg)
        begin
            ctl.relax = 1'b1;
        end

        case (state_reg)
            mst_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[AW-1:0];
                mem_wdata = '0;
                cnt_next  = cnt_reg + CW'(1);
            end
            mst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    a_next   = vmod_tbl[vertex_a];
                    b_next   = vmod_tbl[vertex_b];
                    w_next   = edge_weight;
                    cnt_next = '0;
                end
            end
            mst_pkg::ST_ADD_CMP:
            begin
                mem_we = add_upd;
            end
            mst_pkg::ST_ADD_WR2:
            begin
                mem_we    = 1'b1;
                mem_waddr = {b_reg, a_reg};
            end
            mst_pkg::ST_RUN_INIT:
            begin
                ctl.init        = 1'b1;
                ctl.seed        = seed_ok;
                sel_idx         = a_reg;
                total_next      = '0;
                pend_valid_next = 1'b0;
                cnt_next        = '0;
            end
            mst_pkg::ST_SEARCH:
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            mst_pkg::ST_PICK:
            begin
                cnt_next = '0;
                if (cf[MAX_VERTICES-1])
                begin
                    ctl.pick   = 1'b1;
                    sel_idx    = ci[MAX_VERTICES-1];
                    pick_next  = ci[MAX_VERTICES-1];
                    total_next = total_reg + TB'(ck[MAX_VERTICES-1]);
                end
            end
            mst_pkg::ST_RELAX:
            begin
                mem_raddr    = {pick_reg, cnt_reg[VB-1:0]};
                rd_pend_next = 1'b1;
                rv_next      = cnt_reg[VB-1:0];
                cnt_next     = cnt_reg + CW'(1);
            end
            mst_pkg::ST_DRAIN:
            begin
                cnt_next = '0;
            end
            mst_pkg::ST_EMIT:
            begin
                if (!emit_hold)
                begin
                    if (at_end)
                    begin
                        res_valid_next = 1'b1;
                        last_next      = 1'b1;
                        valid_res_next = pend_valid_reg;
                        if (pend_valid_reg)
                        begin
                            parent_next = FB'(pend_parent_reg);
                            child_next  = FB'(pend_child_reg);
                            tw_next     = pend_w_reg;
                            tot_next    = total_reg;
                        end
                        else
                        begin
                            parent_next = '0;
                            child_next  = '0;
                            tw_next     = '0;
                            tot_next    = '0;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CW'(1);
                        if (qual)
                        begin
                            if (pend_valid_reg)
                            begin
                                res_valid_next = 1'b1;
                                last_next      = 1'b0;
                                valid_res_next = 1'b1;
                                parent_next    = FB'(pend_parent_reg);
                                child_next     = FB'(pend_child_reg);
                                tw_next        = pend_w_reg;
                                tot_next       = total_reg;
                            end
                            pend_valid_next  = 1'b1;
                            pend_parent_next = c_parent[j];
                            pend_child_next  = j;
                            pend_w_next      = c_key[j];
                        end
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mst_pkg::ST_CLEAR;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            total_reg      <= '0;
            vcount_reg     <= mst_pkg::VCOUNT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_pend_reg    <= rd_pend_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            total_reg      <= total_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= vertex_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg           <= a_next;
        b_reg           <= b_next;
        w_reg           <= w_next;
        pick_reg        <= pick_next;
        rv_reg          <= rv_next;
        pend_parent_reg <= pend_parent_next;
        pend_child_reg  <= pend_child_next;
        pend_w_reg      <= pend_w_next;
        valid_res_reg   <= valid_res_next;
        parent_reg      <= parent_next;
        child_reg       <= child_next;
        tw_reg          <= tw_next;
        tot_reg         <= tot_next;
        last_reg        <= last_next;
    end

    assign cfg_ready        = 1'b1;
    assign res_valid        = res_valid_reg;
    assign valid_res        = valid_res_reg;
    assign parent_vertex    = parent_reg;
    assign child_vertex     = child_reg;
    assign tree_edge_weight = tw_reg;
    assign total_weight     = tot_reg;
    assign last             = last_reg;

endmodule

`default_nettype wire

@@ design/mst_checker.sv @@
// Port-level checker for the Prim spanning tree block, with its bind.
`default_nettype none

module mst_checker #(
    parameter int WEIGHT_BITS = mst_pkg::WEIGHT_BITS_DEF
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   item_valid,
    input wire logic                   item_stall,
    input wire logic [1:0]             opcode,
    input wire logic                   res_valid,
    input wire logic                   res_stall,
    input wire logic                   valid_res,
    input wire logic [4:0]             child_vertex,
    input wire logic [WEIGHT_BITS-1:0] tree_edge_weight,
    input wire logic [20:0]            total_weight,
    input wire logic                   last
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(child_vertex))
        else $error("result dropped or changed while stalled");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !valid_res |-> last)
        else $error("empty run result not marked last");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !valid_res |-> total_weight == '0 && child_vertex == '0
                                    && tree_edge_weight == '0)
        else $error("empty run result carries data");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && opcode != mst_pkg::OP_NOP |=> item_stall)
        else $error("request taken without going busy");

endmodule

bind minimum_spanning_tree_prim mst_checker #(.WEIGHT_BITS(WEIGHT_BITS)) u_mst_checker (.*);

`default_nettype wire
